@@ hw/rtl/epl_pkg.sv @@
// Shared types and constants for the edge and palette pixel labeler.
// No dependencies; imported by every module of the block.
package epl_pkg;
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_FRAME = 2'd2;

    localparam logic [1:0] CLS_REGION = 2'd0;
    localparam logic [1:0] CLS_WATER  = 2'd1;
    localparam logic [1:0] CLS_BORDER = 2'd2;
    localparam logic [1:0] CLS_FULL   = 2'd3;

    localparam logic [23:0] WHITE_PIX = 24'hFFFFFF;

    // Summed absolute channel difference of two BGR pixels.
    function automatic logic [9:0] pix_diff(input logic [23:0] a, input logic [23:0] b);
        logic [7:0] d0, d1, d2;
        d0 = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
        d1 = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
        d2 = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
        return {2'b00, d0} + {2'b00, d1} + {2'b00, d2};
    endfunction
endpackage

@@ hw/rtl/epl_cell.sv @@
// One palette compare cell: holds a color and its valid bit.
// Depends on epl_pkg.
module epl_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_load,
    input  logic [23:0] i_color,
    input  logic        i_hit_in,
    output logic        o_hit_out,
    output logic        o_match
);
    import epl_pkg::*;

    logic [23:0] r_color;
    logic        r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end
        if (i_load) begin
            r_color <= i_color;
        end
    end

    assign o_match   = r_valid && (r_color == i_color) && !i_hit_in;
    assign o_hit_out = i_hit_in || (r_valid && (r_color == i_color));
endmodule

@@ hw/rtl/epl_palette.sv @@
// Palette of first-seen colors as a row of compare cells with a priority chain.
// Depends on epl_pkg and epl_cell.
module epl_palette #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_load,
    input  logic [$clog2(DEPTH)-1:0]   i_load_idx,
    input  logic [23:0]                i_color,
    output logic                       o_hit,
    output logic [$clog2(DEPTH)-1:0]   o_idx
);
    import epl_pkg::*;
    localparam int IW = $clog2(DEPTH);

    logic [DEPTH:0]   w_chain;
    logic [DEPTH-1:0] w_match;

    assign w_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        epl_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (i_clear),
            .i_load    (i_load && (i_load_idx == IW'(g))),
            .i_color   (i_color),
            .i_hit_in  (w_chain[g]),
            .o_hit_out (w_chain[g+1]),
            .o_match   (w_match[g])
        );
    end

    // At most one first-match bit is set, so an OR of indexes encodes it.
    always_comb begin
        o_idx = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_match[k]) o_idx = o_idx | IW'(k);
        end
    end
    assign o_hit = w_chain[DEPTH];
endmodule

@@ hw/rtl/edge_and_palette_pixel_labeler.sv @@
// Top level of the edge and palette pixel labeler: line stores, control, output stage.
// Depends on epl_pkg and epl_palette.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | tvalid/tready          | tdata opcode,blue,green,red
//  m_axis   | out | tvalid/tready          | tdata class,index,new; tlast last
//  apb      | in  | psel/penable/pready    | threshold @0, width @4
//
// A pixel beat steps through accept, read and label states: accept issues the line-store
// reads, a read state issues the right-neighbour read, and a label state compares in all
// palette cells. A flush beat adds one more read state, for its third line-store read.
// Frame and ignored beats end at accept. Line stores and palette colors are undefined until
// written. A held output beat stalls only the next label cycle, not intake of the next beat.
module edge_and_palette_pixel_labeler #(
    parameter int MAX_WIDTH     = 1024,
    parameter int PALETTE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // opcode[1:0], blue[9:2], green[17:10], red[25:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_class[1:0], color_index[11:2], new_color[12]
    output logic        m_axis_tlast,   // last_pixel
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import epl_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = $clog2(PALETTE_DEPTH);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_LAB  = 2'd2;
    localparam logic [1:0] ST_FL2  = 2'd3;
    localparam logic [2:0] ADDR_THR = 3'd0;
    localparam logic [2:0] ADDR_WID = 3'd4;

    logic [9:0]  r_thr;
    logic [10:0] r_width;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= 10'd5;
            r_width <= 11'd1024;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_THR) r_thr <= pwdata[9:0];
            if (paddr == ADDR_WID) r_width <= pwdata[10:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_THR) prdata = {22'd0, r_thr};
        else if (paddr == ADDR_WID) prdata = {21'd0, r_width};
    end

    logic [12:0] w_w;
    always_comb begin
        if (r_width == 11'd0) w_w = 13'd1;
        else if ({2'b00, r_width} > 13'(MAX_WIDTH)) w_w = 13'(MAX_WIDTH);
        else w_w = {2'b00, r_width};
    end

    // Line stores; one read port per store, registered.
    logic [23:0] r_up [MAX_WIDTH];
    logic [23:0] r_mid [MAX_WIDTH];
    logic [23:0] r_up_q, r_mid_q;
    logic        up_we, mid_we, mid_re, up_re;
    logic [CW-1:0] up_wa, mid_wa, mid_ra, up_ra;
    logic [23:0] up_wd, mid_wd;

    always_ff @(posedge i_clk) begin
        if (up_we) r_up[up_wa] <= up_wd;
        if (up_re) r_up_q <= r_up[up_ra];
    end
    always_ff @(posedge i_clk) begin
        if (mid_we) r_mid[mid_wa] <= mid_wd;
        if (mid_re) r_mid_q <= r_mid[mid_ra];
    end

    logic [1:0]  r_state, n_state;
    logic [12:0] r_col, n_col;
    logic [1:0]  r_rows, n_rows;
    logic [12:0] r_flp, n_flp;
    logic [12:0] r_pal, n_pal;
    logic [23:0] r_left, n_left;
    logic [23:0] r_cur, n_cur;
    logic        r_flush, n_flush;
    logic [23:0] r_a, n_a;   // pixel being labeled (old middle) on a pixel beat
    logic [23:0] r_b, n_b;   // top neighbour captured on a pixel beat, left on flush
    logic [1:0]  r_ocls;
    logic [9:0]  r_oidx;
    logic        r_onew, r_olast, r_ovalid;

    logic        pal_clear, pal_load, pal_hit;
    logic [PW-1:0] pal_idx;
    logic [23:0] lab_pix;

    epl_palette #(.DEPTH(PALETTE_DEPTH)) u_palette (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (pal_clear),
        .i_load     (pal_load),
        .i_load_idx (r_pal[PW-1:0]),
        .i_color    (lab_pix),
        .o_hit      (pal_hit),
        .o_idx      (pal_idx)
    );

    logic in_fire, out_free;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    // Label decision, combinational in the label cycle.
    logic        d_edge, d_emit;
    logic [1:0]  d_cls;
    logic [9:0]  d_idx;
    logic        d_new, d_last;
    logic [23:0] nb_l, nb_r, nb_t, nb_b;
    logic        h_l, h_r, h_t, h_b;

    always_comb begin
        if (!r_flush) begin
            lab_pix = r_a;
            nb_l = r_left;  h_l = (r_col != 13'd0);
            nb_r = r_mid_q; h_r = (r_col + 13'd1 < w_w);
            nb_t = r_b;     h_t = (r_rows >= 2'd2);
            nb_b = r_cur;   h_b = 1'b1;
        end else begin
            lab_pix = r_a;
            nb_l = r_b;     h_l = (r_flp != 13'd0);
            nb_r = r_mid_q; h_r = (r_flp + 13'd1 < w_w);
            nb_t = r_up_q;  h_t = (r_rows >= 2'd2);
            nb_b = '0;      h_b = 1'b0;
        end
        if (!h_l) d_edge = 1'b0;
        else if (pix_diff(lab_pix, nb_l) > r_thr) d_edge = 1'b1;
        else if (!h_r) d_edge = 1'b0;
        else if (pix_diff(lab_pix, nb_r) > r_thr) d_edge = 1'b1;
        else if (!h_t) d_edge = 1'b0;
        else if (pix_diff(lab_pix, nb_t) > r_thr) d_edge = 1'b1;
        else if (!h_b) d_edge = 1'b0;
        else d_edge = (pix_diff(lab_pix, nb_b) > r_thr);

        d_idx = '0; d_new = 1'b0; pal_load = 1'b0;
        if (lab_pix == WHITE_PIX) d_cls = CLS_WATER;
        else if (lab_pix == 24'd0 || d_edge) d_cls = CLS_BORDER;
        else if (pal_hit) begin
            d_cls = CLS_REGION; d_idx = 10'(pal_idx);
        end else if (r_pal < 13'(PALETTE_DEPTH)) begin
            d_cls = CLS_REGION; d_idx = 10'(r_pal); d_new = 1'b1; pal_load = d_emit;
        end else d_cls = CLS_FULL;
        d_last = r_flush && (r_flp + 13'd1 >= w_w);
    end
    assign d_emit = (r_state == ST_LAB) && out_free && (r_flush || r_rows != 2'd0);

    always_comb begin
        n_state = r_state; n_col = r_col; n_rows = r_rows; n_flp = r_flp; n_pal = r_pal;
        n_left = r_left; n_cur = r_cur; n_flush = r_flush; n_a = r_a; n_b = r_b;
        up_we = 1'b0; mid_we = 1'b0; up_wa = '0; mid_wa = '0; up_wd = r_a; mid_wd = r_cur;
        mid_re = 1'b0; up_re = 1'b0; mid_ra = '0; up_ra = '0;
        pal_clear = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_axis_tdata[1:0])
                        OP_FRAME: begin
                            n_col = '0; n_rows = '0; n_flp = '0; n_pal = '0; n_left = '0;
                            pal_clear = 1'b1;
                        end
                        OP_PIXEL: begin
                            if (r_flp == 13'd0) begin
                                n_cur = {s_axis_tdata[25:18], s_axis_tdata[17:10],
                                         s_axis_tdata[9:2]};
                                n_flush = 1'b0;
                                mid_re = 1'b1; up_re = 1'b1;
                                mid_ra = r_col[CW-1:0]; up_ra = r_col[CW-1:0];
                                n_state = ST_RD;
                            end
                        end
                        OP_FLUSH: begin
                            if (r_rows != 2'd0 && r_col == 13'd0 && r_flp < w_w) begin
                                n_flush = 1'b1;
                                mid_re = 1'b1; up_re = 1'b1;
                                mid_ra = r_flp[CW-1:0]; up_ra = r_flp[CW-1:0];
                                n_state = ST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD: begin
                n_a = r_mid_q;
                if (!r_flush) begin
                    n_b = r_up_q;
                    mid_re = (r_col + 13'd1 < 13'(MAX_WIDTH));
                    mid_ra = CW'(r_col + 13'd1);
                    up_we = 1'b1; up_wa = r_col[CW-1:0]; up_wd = r_mid_q;
                    n_state = ST_LAB;
                end else begin
                    mid_re = 1'b1; mid_ra = CW'(r_flp - 13'd1);
                    n_state = ST_FL2;
                end
            end
            ST_FL2: begin
                n_b = r_mid_q;
                mid_re = 1'b1; mid_ra = CW'(r_flp + 13'd1);
                n_state = ST_LAB;
            end
            ST_LAB: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                    if (pal_load) n_pal = r_pal + 13'd1;
                    if (r_flush) begin
                        n_flp = r_flp + 13'd1;
                    end else begin
                        mid_we = 1'b1; mid_wa = r_col[CW-1:0]; mid_wd = r_cur;
                        n_left = r_a;
                        if (r_col + 13'd1 >= w_w) begin
                            n_col = '0; n_left = '0;
                            if (r_rows < 2'd2) n_rows = r_rows + 2'd1;
                        end else n_col = r_col + 13'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_col <= '0; r_rows <= '0; r_flp <= '0; r_pal <= '0;
            r_left <= '0; r_flush <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_col <= n_col; r_rows <= n_rows; r_flp <= n_flp;
            r_pal <= n_pal; r_left <= n_left; r_flush <= n_flush;
            if (d_emit) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
        r_cur <= n_cur; r_a <= n_a; r_b <= n_b;
        if (d_emit) begin
            r_ocls <= d_cls; r_oidx <= d_idx; r_onew <= d_new; r_olast <= d_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_onew, r_oidx, r_ocls};
    assign m_axis_tlast  = r_olast;

    a_pal_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pal <= 13'(PALETTE_DEPTH)) else $error("palette count overflow");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_new_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_emit && d_new |-> d_cls == CLS_REGION) else $error("new color not region");
endmodule
